// File: rtl/core/rotary_knob_setpoint_accel_defines.svh
// Assertion helpers shared by the knob setpoint RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ROTARY_KNOB_SETPOINT_ACCEL_DEFINES_SVH
`define ROTARY_KNOB_SETPOINT_ACCEL_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RKSA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RKSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rksa_pkg.sv
package rksa_pkg;

  // Edge counter width; the measured rate is three times a count, so two more bits.
  localparam int COUNT_WIDTH = 16;
  localparam int RATE_MUL    = 60;
  localparam int RATE_DIV    = 20;
  localparam int RATE_FACTOR = RATE_MUL / RATE_DIV;
  localparam int RATE_WIDTH  = COUNT_WIDTH + 2;

  localparam int VALUE_WIDTH  = 16;
  localparam int STEP_WIDTH   = 8;
  localparam int THRESH_WIDTH = 16;
  localparam int CMP_WIDTH    = (RATE_WIDTH > THRESH_WIDTH) ? RATE_WIDTH : THRESH_WIDTH;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  localparam int IN_DATA_WIDTH  = 8;
  localparam int IN_USER_WIDTH  = 2;
  localparam int OUT_DATA_WIDTH = 40;

  // Command queue between the front and the back; depth is a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic KNOB_SEL_TEMP  = 1'b0;
  localparam logic KNOB_SEL_SPEED = 1'b1;

  localparam logic [1:0] KNOB_NONE  = 2'd0;
  localparam logic [1:0] KNOB_TEMP  = 2'd1;
  localparam logic [1:0] KNOB_SPEED = 2'd2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_FAST_THRESHOLD = 3'd0,
    REG_SLOW_STEP      = 3'd1,
    REG_FAST_STEP      = 3'd2,
    REG_TEMP_LIMIT     = 3'd3,
    REG_SPEED_LIMIT    = 3'd4,
    REG_SPEED_FLOOR    = 3'd5
  } cfg_reg_t;

  localparam logic [THRESH_WIDTH-1:0] RESET_FAST_THRESHOLD = 16'd30;
  localparam logic [STEP_WIDTH-1:0]   RESET_SLOW_STEP      = 8'd10;
  localparam logic [STEP_WIDTH-1:0]   RESET_FAST_STEP      = 8'd30;
  localparam logic [VALUE_WIDTH-1:0]  RESET_TEMP_LIMIT     = 16'd3500;
  localparam logic [VALUE_WIDTH-1:0]  RESET_SPEED_LIMIT    = 16'd1500;
  localparam logic [VALUE_WIDTH-1:0]  RESET_SPEED_FLOOR    = 16'd200;

  typedef struct packed {
    logic tick;
    logic knob;
    logic down;
  } cmd_t;

  typedef struct packed {
    logic [THRESH_WIDTH-1:0] fast_threshold;
    logic [STEP_WIDTH-1:0]   slow_step;
    logic [STEP_WIDTH-1:0]   fast_step;
    logic [VALUE_WIDTH-1:0]  temp_limit;
    logic [VALUE_WIDTH-1:0]  speed_limit;
    logic [VALUE_WIDTH-1:0]  speed_floor;
  } cfg_t;

endpackage

// File: rtl/core/rotary_knob_setpoint_accel.sv
// Two-knob setpoint adjuster with rate-based acceleration.
// An accepted item is written into the command queue, then executed into the result register.
// Throughput: one item per cycle while the result is not held; each item is one update of the knob state.
// A stalled result holds the execute stage; the 2-entry command queue absorbs the input side.
// Reset (rst, synchronous): counts, rates, setpoints cleared, registers to defaults.
module rotary_knob_setpoint_accel
  import rksa_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [IN_DATA_WIDTH-1:0]   s_axis_tdata,   // [0] b_level, rest zero
  input  logic [IN_USER_WIDTH-1:0]   s_axis_tuser,   // [0] mode, [1] knob_select
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [15:0] temp_setpoint, [31:16] speed_setpoint, [33:32] adjusted_knob,
  // [34] blink_request, rest zero
  output logic [OUT_DATA_WIDTH-1:0]  m_axis_tdata,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;

  rksa_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_cmd         (q_cmd),
    .q_valid       (q_valid),
    .q_pop         (q_pop)
  );

  rksa_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_cmd         (q_cmd),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: rtl/core/rksa_front.sv
`include "rotary_knob_setpoint_accel_defines.svh"

module rksa_front
  import rksa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_DATA_WIDTH-1:0] s_axis_tdata,  // [0] b_level, rest zero
  input  logic [IN_USER_WIDTH-1:0] s_axis_tuser,  // [0] mode, [1] knob_select
  output cmd_t                     q_cmd,
  output logic                     q_valid,
  input  logic                     q_pop
);

  cmd_t                  entries [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr;
  logic [QPTR_WIDTH-1:0] rd_ptr;
  logic [QCNT_WIDTH-1:0] count;
  cmd_t                  in_cmd;
  logic                  push;
  logic                  pop;

  always_comb begin
    in_cmd.tick = (s_axis_tuser[0] == MODE_TICK);
    in_cmd.knob = s_axis_tuser[1];
    in_cmd.down = s_axis_tdata[0];
  end

  assign s_axis_tready = (count != QCNT_WIDTH'(QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != '0);
  assign pop           = q_pop && q_valid;
  assign q_cmd         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `RKSA_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "queue count missed a push")
  `RKSA_ASSERT_NEXT(a_count_down, pop && !push, count == $past(count) - 1'b1, "queue count missed a pop")
  `RKSA_ASSERT_SAME(a_ptr_gap, 1'b1, count == QCNT_WIDTH'(QPTR_WIDTH'(wr_ptr - rd_ptr)) || count == QCNT_WIDTH'(QUEUE_DEPTH), "queue pointers disagree with count")

endmodule

// File: rtl/core/rksa_back.sv
`include "rotary_knob_setpoint_accel_defines.svh"

module rksa_back
  import rksa_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       q_cmd,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [15:0] temp_setpoint, [31:16] speed_setpoint, [33:32] adjusted_knob,
  // [34] blink_request, rest zero
  output logic [OUT_DATA_WIDTH-1:0]  m_axis_tdata
);

  cfg_t                   cfg;
  logic [COUNT_WIDTH-1:0] edge_count [2];
  logic [RATE_WIDTH-1:0]  knob_rate  [2];
  logic [VALUE_WIDTH-1:0] temp_value;
  logic [VALUE_WIDTH-1:0] speed_value;
  logic [1:0]             last_knob;
  logic                   blink;

  logic [RATE_WIDTH-1:0]  sel_rate;
  logic [STEP_WIDTH-1:0]  step;
  logic [VALUE_WIDTH:0]   temp_sum;
  logic [VALUE_WIDTH-1:0] temp_up;
  logic [VALUE_WIDTH-1:0] temp_dn;
  logic [VALUE_WIDTH:0]   speed_sum;
  logic [VALUE_WIDTH:0]   speed_base;
  logic [VALUE_WIDTH-1:0] speed_up;
  logic [VALUE_WIDTH-1:0] speed_diff;
  logic [VALUE_WIDTH-1:0] speed_dn;
  logic [VALUE_WIDTH-1:0] temp_next;
  logic [VALUE_WIDTH-1:0] speed_next;

  // A command is executed only when the result register is free or drains now.
  assign q_pop = q_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_threshold <= RESET_FAST_THRESHOLD;
      cfg.slow_step      <= RESET_SLOW_STEP;
      cfg.fast_step      <= RESET_FAST_STEP;
      cfg.temp_limit     <= RESET_TEMP_LIMIT;
      cfg.speed_limit    <= RESET_SPEED_LIMIT;
      cfg.speed_floor    <= RESET_SPEED_FLOOR;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FAST_THRESHOLD: cfg.fast_threshold <= THRESH_WIDTH'(cfg_data);
        REG_SLOW_STEP:      cfg.slow_step      <= cfg_data[STEP_WIDTH-1:0];
        REG_FAST_STEP:      cfg.fast_step      <= cfg_data[STEP_WIDTH-1:0];
        REG_TEMP_LIMIT:     cfg.temp_limit     <= VALUE_WIDTH'(cfg_data);
        REG_SPEED_LIMIT:    cfg.speed_limit    <= VALUE_WIDTH'(cfg_data);
        REG_SPEED_FLOOR:    cfg.speed_floor    <= VALUE_WIDTH'(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    sel_rate = knob_rate[q_cmd.knob];
    step = (CMP_WIDTH'(sel_rate) < CMP_WIDTH'(cfg.fast_threshold)) ?
           cfg.slow_step : cfg.fast_step;

    temp_sum = {1'b0, temp_value} + (VALUE_WIDTH + 1)'(step);
    temp_up  = (temp_sum > {1'b0, cfg.temp_limit}) ? cfg.temp_limit
                                                   : temp_sum[VALUE_WIDTH-1:0];
    temp_dn  = (temp_value < VALUE_WIDTH'(step)) ? '0 : temp_value - VALUE_WIDTH'(step);

    // Turning up from zero lands on the floor before the limit is applied.
    speed_sum  = {1'b0, speed_value} + (VALUE_WIDTH + 1)'(step);
    speed_base = (speed_value == '0) ? {1'b0, cfg.speed_floor} : speed_sum;
    speed_up   = (speed_base > {1'b0, cfg.speed_limit}) ? cfg.speed_limit
                                                        : speed_base[VALUE_WIDTH-1:0];
    speed_diff = speed_value - VALUE_WIDTH'(step);
    speed_dn   = ((speed_value < VALUE_WIDTH'(step)) || (speed_diff < cfg.speed_floor)) ?
                 '0 : speed_diff;

    temp_next  = temp_value;
    speed_next = speed_value;
    if (!q_cmd.tick) begin
      if (q_cmd.knob == KNOB_SEL_TEMP) begin
        temp_next = q_cmd.down ? temp_dn : temp_up;
      end else begin
        speed_next = q_cmd.down ? speed_dn : speed_up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count[0] <= '0;
      edge_count[1] <= '0;
      knob_rate[0]  <= '0;
      knob_rate[1]  <= '0;
      temp_value    <= '0;
      speed_value   <= '0;
      last_knob     <= KNOB_NONE;
      blink         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (q_pop) begin
        m_axis_tvalid <= 1'b1;
        blink         <= !q_cmd.tick;
        temp_value    <= temp_next;
        speed_value   <= speed_next;
        if (q_cmd.tick) begin
          for (int i = 0; i < 2; i++) begin
            knob_rate[i]  <= RATE_WIDTH'(edge_count[i]) * RATE_WIDTH'(RATE_FACTOR);
            edge_count[i] <= '0;
          end
        end else begin
          if (edge_count[q_cmd.knob] != '1) begin
            edge_count[q_cmd.knob] <= edge_count[q_cmd.knob] + 1'b1;
          end
          last_knob <= (q_cmd.knob == KNOB_SEL_TEMP) ? KNOB_TEMP : KNOB_SPEED;
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // The setpoint state only moves when a result is free to leave, so it
  // doubles as the result payload.
  assign m_axis_tdata = {(OUT_DATA_WIDTH - 2 * VALUE_WIDTH - 3)'(0), blink, last_knob,
                         speed_value, temp_value};

  `RKSA_ASSERT_NEXT(a_tick_clears, q_pop && q_cmd.tick, edge_count[0] == '0 && edge_count[1] == '0, "tick left an edge count")
  `RKSA_ASSERT_NEXT(a_speed_floor, q_pop && !q_cmd.tick && q_cmd.knob == KNOB_SEL_SPEED && q_cmd.down, speed_value == '0 || speed_value >= $past(cfg.speed_floor), "speed fell below floor")
  `RKSA_ASSERT_NEXT(a_blink_kind, q_pop, m_axis_tvalid && blink == !$past(q_cmd.tick), "result flag does not match item kind")
  `RKSA_ASSERT_SAME(a_no_overrun, m_axis_tvalid && !m_axis_tready, !q_pop, "command executed over a held result")

endmodule
